>>> design/tnc_pkg.sv
// Shared constants, types and the tile code function of the neighbour code block.
package tnc_pkg;

   localparam int GRID_W_DEF = 32;
   localparam int GRID_H_DEF = 32;

   localparam int POS_W = 5;
   localparam int POS_SPAN = 32;
   localparam int CODE_W = 5;

   // rows r-2 .. r+2 land in five distinct banks when banked by row mod 5
   localparam int ROW_BANKS = 5;
   localparam int BANK_SEL_W = 3;
   localparam int ROW_SPAN = 5;
   localparam int ROW_SEL_W = 3;
   localparam int HALF_SPAN = 2;

   localparam int NEAR_CELLS = 8;
   localparam int STENCIL_CELLS = 12;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CODE_W-1:0] CODE_CORNER = 5'd16;
   localparam logic [CODE_W-1:0] CODE_FULL = 5'd20;
   localparam logic [3:0] EDGE_MASK = 4'b1111;

   // up, left, right, down, four diagonals, then the four cells at distance two
   localparam logic signed [2:0] STENCIL_DX [STENCIL_CELLS] = '{
      3'sd0, -3'sd1, 3'sd1, 3'sd0, -3'sd1, 3'sd1, -3'sd1, 3'sd1,
      3'sd0, -3'sd2, 3'sd2, 3'sd0};
   localparam logic signed [2:0] STENCIL_DY [STENCIL_CELLS] = '{
      -3'sd1, 3'sd0, 3'sd0, 3'sd1, -3'sd1, -3'sd1, 3'sd1, 3'sd1,
      -3'sd2, 3'sd0, 3'sd0, 3'sd2};

   typedef struct packed {
      logic outside;
      logic live;
   } row_state_type;

   function automatic logic [CODE_W-1:0] tile_code_of(input logic [STENCIL_CELLS-1:0] solid);
      logic [3:0] near_count;
      logic [2:0] far_count;
      logic [2:0] empty_slot;
      logic [CODE_W-1:0] code;
      near_count = '0;
      far_count = '0;
      empty_slot = '0;
      for (int n = 0; n < NEAR_CELLS; n++) begin
         if (solid[n]) begin
            near_count = near_count + 4'd1;
         end else begin
            empty_slot = 3'(n);
         end
      end
      for (int n = NEAR_CELLS; n < STENCIL_CELLS; n++) begin
         if (solid[n]) begin
            far_count = far_count + 3'd1;
         end
      end
      // inner corner: the single empty near cell is a diagonal
      if (near_count == 4'(NEAR_CELLS - 1) && empty_slot[2]) begin
         code = CODE_CORNER + {3'b000, empty_slot[1:0]};
      end else if (near_count == 4'(NEAR_CELLS) &&
                   far_count == 3'(STENCIL_CELLS - NEAR_CELLS)) begin
         code = CODE_FULL;
      end else begin
         code = {1'b0, solid[3:0] & EDGE_MASK};
      end
      return code;
   endfunction

endpackage

>>> design/tnc_grid.sv
// Occupancy grid in five row banks with row valid bits; registers the five stencil rows.
module tnc_grid #(
   parameter int GRID_W = tnc_pkg::GRID_W_DEF,
   parameter int GRID_H = tnc_pkg::GRID_H_DEF,
   localparam int STORE_W = (GRID_W < tnc_pkg::POS_SPAN) ? GRID_W : tnc_pkg::POS_SPAN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           kind,
   input  logic [tnc_pkg::POS_W-1:0]      col,
   input  logic [tnc_pkg::POS_W-1:0]      row,
   input  logic                           occupied,
   output logic [STORE_W-1:0]             bank_word_ff [tnc_pkg::ROW_BANKS],
   output logic [tnc_pkg::BANK_SEL_W-1:0] row_bank_ff [tnc_pkg::ROW_SPAN],
   output tnc_pkg::row_state_type         row_state_ff [tnc_pkg::ROW_SPAN]
);

   localparam int STORE_H = (GRID_H < tnc_pkg::POS_SPAN) ? GRID_H : tnc_pkg::POS_SPAN;
   localparam int BANK_DEPTH = (STORE_H + tnc_pkg::ROW_BANKS - 1) / tnc_pkg::ROW_BANKS;
   localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int ROW_IDX_W = $clog2(STORE_H);
   localparam int COL_IDX_W = $clog2(STORE_W);
   localparam int GROUPS = (tnc_pkg::POS_SPAN - 1) / tnc_pkg::ROW_BANKS;
   localparam int GRP_W = $clog2(GROUPS + 1);
   localparam int ROW_CALC_W = tnc_pkg::POS_W + 2;

   logic [STORE_H-1:0]             row_valid_ff;
   logic [GRP_W-1:0]               home_grp;
   logic [tnc_pkg::BANK_SEL_W-1:0] home_bank;

   logic signed [ROW_CALC_W-1:0]   near_row [tnc_pkg::ROW_SPAN];
   logic signed [GRP_W+1:0]        near_grp [tnc_pkg::ROW_SPAN];
   logic                           near_stored [tnc_pkg::ROW_SPAN];
   logic [tnc_pkg::BANK_SEL_W-1:0] near_bank [tnc_pkg::ROW_SPAN];
   tnc_pkg::row_state_type         near_state [tnc_pkg::ROW_SPAN];
   logic [BANK_AW-1:0]             rd_addr [tnc_pkg::ROW_BANKS];

   logic                           wr_en;
   logic [BANK_AW-1:0]             wr_addr;
   logic [COL_IDX_W-1:0]           wr_col;
   logic [ROW_IDX_W-1:0]           wr_row;
   logic [STORE_W-1:0]             wr_word;
   logic [STORE_W-1:0]             wr_mask;

   // split the addressed row into bank group and bank (row div 5, row mod 5)
   always_comb begin
      home_grp = '0;
      for (int i = 1; i <= GROUPS; i++) begin
         if (int'(row) >= i * tnc_pkg::ROW_BANKS) begin
            home_grp = home_grp + 1'b1;
         end
      end
      home_bank = tnc_pkg::BANK_SEL_W'(row - tnc_pkg::POS_W'(int'(home_grp) * tnc_pkg::ROW_BANKS));
   end

   always_comb begin
      logic signed [4:0] slot;
      logic [3:0]        wrap;
      for (int k = 0; k < tnc_pkg::ROW_SPAN; k++) begin
         near_row[k] = $signed({2'b00, row}) + ROW_CALC_W'(k - tnc_pkg::HALF_SPAN);
         near_state[k].outside = (near_row[k] < 0) || (int'(near_row[k]) >= GRID_H);
         near_stored[k] = !near_state[k].outside && (int'(near_row[k]) < STORE_H);
         near_state[k].live = near_stored[k] &&
                              row_valid_ff[near_row[k][ROW_IDX_W-1:0]];
         slot = $signed({2'b00, home_bank}) + 5'(k - tnc_pkg::HALF_SPAN);
         if (slot < 0) begin
            near_grp[k] = $signed({2'b00, home_grp}) - (GRP_W+2)'(1);
         end else if (slot >= 5'(tnc_pkg::ROW_BANKS)) begin
            near_grp[k] = $signed({2'b00, home_grp}) + (GRP_W+2)'(1);
         end else begin
            near_grp[k] = $signed({2'b00, home_grp});
         end
         wrap = 4'(int'(home_bank) + k + tnc_pkg::ROW_BANKS - tnc_pkg::HALF_SPAN);
         if (wrap >= 4'(2 * tnc_pkg::ROW_BANKS)) begin
            wrap = wrap - 4'(2 * tnc_pkg::ROW_BANKS);
         end else if (wrap >= 4'(tnc_pkg::ROW_BANKS)) begin
            wrap = wrap - 4'(tnc_pkg::ROW_BANKS);
         end
         near_bank[k] = wrap[tnc_pkg::BANK_SEL_W-1:0];
      end
   end

   // each bank serves at most one of the five stencil rows
   always_comb begin
      for (int j = 0; j < tnc_pkg::ROW_BANKS; j++) begin
         rd_addr[j] = '0;
         for (int k = 0; k < tnc_pkg::ROW_SPAN; k++) begin
            if (near_stored[k] && near_bank[k] == tnc_pkg::BANK_SEL_W'(j)) begin
               rd_addr[j] = near_grp[k][BANK_AW-1:0];
            end
         end
      end
   end

   assign wr_en = accept && (kind == tnc_pkg::KIND_WRITE) &&
                  (int'(col) < GRID_W) && (int'(row) < GRID_H);
   assign wr_addr = home_grp[BANK_AW-1:0];
   assign wr_col = col[COL_IDX_W-1:0];
   assign wr_row = row[ROW_IDX_W-1:0];
   assign wr_word = STORE_W'(occupied) << wr_col;
   // a row never written since reset takes the whole word, clearing the rest
   assign wr_mask = row_valid_ff[wr_row] ? (STORE_W'(1) << wr_col) : '1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_row] <= 1'b1;
      end
   end

   for (genvar j = 0; j < tnc_pkg::ROW_BANKS; j++) begin : g_bank
      logic [STORE_W-1:0] bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && home_bank == tnc_pkg::BANK_SEL_W'(j)) begin
            for (int b = 0; b < STORE_W; b++) begin
               if (wr_mask[b]) begin
                  bank_mem[wr_addr][b] <= wr_word[b];
               end
            end
         end
         bank_word_ff[j] <= bank_mem[rd_addr[j]];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < tnc_pkg::ROW_SPAN; k++) begin
         row_bank_ff[k] <= near_bank[k];
         row_state_ff[k] <= near_state[k];
      end
   end

endmodule

>>> design/tile_neighbour_code.sv
// Tile neighbour code: occupancy grid with 12-cell stencil autotile lookup.
// The start beat and the stencil rows are registered first, then the result and its strobe.
// Throughput: one beat per cycle outside reset; the five stencil rows come from five row banks,
// one read port each, so no beat waits on a shared port. busy is high only in reset.
// Reset (synchronous): clears the row valid bits, so the whole grid reads empty,
// and drops any pending result; the receiver cannot stall.
module tile_neighbour_code #(
   parameter int GRID_W = tnc_pkg::GRID_W_DEF,
   parameter int GRID_H = tnc_pkg::GRID_H_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [tnc_pkg::POS_W-1:0]  req_col,
   input  logic [tnc_pkg::POS_W-1:0]  req_row,
   input  logic                       req_occupied,
   output logic                       rsp_strobe,
   output logic                       rsp_cell_visible,
   output logic [tnc_pkg::CODE_W-1:0] rsp_tile_code,
   output logic                       rsp_in_grid
);

   localparam int STORE_W = (GRID_W < tnc_pkg::POS_SPAN) ? GRID_W : tnc_pkg::POS_SPAN;
   localparam int COL_IDX_W = $clog2(STORE_W);
   localparam int COL_CALC_W = tnc_pkg::POS_W + 2;

   logic                           accept;
   logic                           item_valid_ff;
   logic                           kind_ff;
   logic [tnc_pkg::POS_W-1:0]      col_ff;
   logic [tnc_pkg::POS_W-1:0]      row_ff;

   logic [STORE_W-1:0]             bank_word [tnc_pkg::ROW_BANKS];
   logic [tnc_pkg::BANK_SEL_W-1:0] row_bank [tnc_pkg::ROW_SPAN];
   tnc_pkg::row_state_type         row_state [tnc_pkg::ROW_SPAN];

   logic [tnc_pkg::STENCIL_CELLS-1:0] solid;
   logic [STORE_W-1:0]             center_word;
   logic                           in_grid;
   logic                           visible;
   logic [tnc_pkg::CODE_W-1:0]     code;

   logic                           rsp_strobe_ff;
   logic                           rsp_cell_visible_ff;
   logic [tnc_pkg::CODE_W-1:0]     rsp_tile_code_ff;
   logic                           rsp_in_grid_ff;

   assign busy = reset;
   assign accept = start && !busy;

   tnc_grid #(
      .GRID_W(GRID_W),
      .GRID_H(GRID_H)
   ) u_grid (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .col          (req_col),
      .row          (req_row),
      .occupied     (req_occupied),
      .bank_word_ff (bank_word),
      .row_bank_ff  (row_bank),
      .row_state_ff (row_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= req_kind;
      col_ff <= req_col;
      row_ff <= req_row;
   end

   always_comb begin
      logic signed [COL_CALC_W-1:0]   x;
      logic [tnc_pkg::ROW_SEL_W-1:0]  row_k;
      logic [STORE_W-1:0]             row_word;
      for (int n = 0; n < tnc_pkg::STENCIL_CELLS; n++) begin
         row_k = tnc_pkg::ROW_SEL_W'(int'(tnc_pkg::STENCIL_DY[n]) + tnc_pkg::HALF_SPAN);
         x = $signed({2'b00, col_ff}) + COL_CALC_W'(tnc_pkg::STENCIL_DX[n]);
         row_word = bank_word[row_bank[row_k]];
         // off the grid counts as occupied; in the grid but in an unwritten row or past the address range, empty
         if (row_state[row_k].outside || x < 0 || int'(x) >= GRID_W) begin
            solid[n] = 1'b1;
         end else if (!row_state[row_k].live || int'(x) >= STORE_W) begin
            solid[n] = 1'b0;
         end else begin
            solid[n] = row_word[x[COL_IDX_W-1:0]];
         end
      end
   end

   assign center_word = bank_word[row_bank[tnc_pkg::HALF_SPAN]];
   assign in_grid = (int'(col_ff) < GRID_W) && (int'(row_ff) < GRID_H);
   assign visible = (kind_ff == tnc_pkg::KIND_QUERY) && in_grid &&
                    row_state[tnc_pkg::HALF_SPAN].live &&
                    center_word[col_ff[COL_IDX_W-1:0]];
   assign code = visible ? tnc_pkg::tile_code_of(solid) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_visible_ff <= visible;
      rsp_tile_code_ff <= code;
      rsp_in_grid_ff <= in_grid;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_cell_visible = rsp_cell_visible_ff;
   assign rsp_tile_code = rsp_tile_code_ff;
   assign rsp_in_grid = rsp_in_grid_ff;

`ifndef SYNTHESIS
   a_strobe_follows_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without a start beat two cycles earlier");

   a_visible_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_cell_visible |-> rsp_in_grid)
      else $error("visible cell reported outside the grid");

   a_code_needs_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_tile_code != '0 |-> rsp_cell_visible)
      else $error("nonzero tile code for a hidden cell");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_tile_code <= tnc_pkg::CODE_FULL)
      else $error("tile code above the full code");

   a_write_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_kind == tnc_pkg::KIND_WRITE, 2) |-> !rsp_cell_visible)
      else $error("write beat reported a visible cell");
`endif

endmodule

>>> tb/tile_neighbour_code_tb.sv
// Testbench for tile_neighbour_code: writes and tile code queries checked against a grid model.
`timescale 1ns / 1ps

module tile_neighbour_code_tb;

   localparam int GRID_W = tnc_pkg::GRID_W_DEF;
   localparam int GRID_H = tnc_pkg::GRID_H_DEF;
   localparam int RANDOM_BEATS = 1100;
   localparam int QUIET_TAIL = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                       kind;
      logic [tnc_pkg::POS_W-1:0]  col;
      logic [tnc_pkg::POS_W-1:0]  row;
      logic                       occupied;
   } grid_beat_type;

   typedef struct packed {
      logic                       visible;
      logic [tnc_pkg::CODE_W-1:0] code;
      logic                       in_grid;
   } tile_reply_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_kind = tnc_pkg::KIND_WRITE;
   logic [tnc_pkg::POS_W-1:0]  req_col = '0;
   logic [tnc_pkg::POS_W-1:0]  req_row = '0;
   logic                       req_occupied = 1'b0;
   logic                       rsp_strobe;
   logic                       rsp_cell_visible;
   logic [tnc_pkg::CODE_W-1:0] rsp_tile_code;
   logic                       rsp_in_grid;

   grid_beat_type  grid_beats_pending [$];
   tile_reply_type tile_replies_due [$];
   logic           grid_bits [GRID_H][GRID_W];
   int             error_count = 0;
   int             cycle_count = 0;
   int             idle_left = 0;
   int             idle_odds = 2;

   // up, left, right, down, four diagonals, then the four cells two away
   int step_dx [12] = '{0, -1, 1, 0, -1, 1, -1, 1, 0, -2, 2, 0};
   int step_dy [12] = '{-1, 0, 0, 1, -1, -1, 1, 1, -2, 0, 0, 2};

   tile_neighbour_code i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_occupied     (req_occupied),
      .rsp_strobe       (rsp_strobe),
      .rsp_cell_visible (rsp_cell_visible),
      .rsp_tile_code    (rsp_tile_code),
      .rsp_in_grid      (rsp_in_grid)
   );

   always #10 clock = ~clock;

   function automatic logic on_grid(int c, int r);
      return c >= 0 && c < GRID_W && r >= 0 && r < GRID_H;
   endfunction

   function automatic logic cell_solid(int c, int r);
      if (!on_grid(c, r)) begin
         return 1'b1;
      end
      return grid_bits[r][c];
   endfunction

   function automatic logic [tnc_pkg::CODE_W-1:0] lookup_tile_code(int c, int r);
      logic [11:0] seen;
      int near_full;
      int far_full;
      int gap;
      near_full = 0;
      far_full = 0;
      gap = 0;
      for (int n = 0; n < 12; n++) begin
         seen[n] = cell_solid(c + step_dx[n], r + step_dy[n]);
         if (seen[n]) begin
            if (n < 8) near_full++;
            else far_full++;
         end else if (n < 8) begin
            gap = n;
         end
      end
      // lone empty diagonal gives an inner corner
      if (near_full == 7 && gap >= 4) begin
         return tnc_pkg::CODE_CORNER + tnc_pkg::CODE_W'(gap - 4);
      end
      if (near_full == 8 && far_full == 4) begin
         return tnc_pkg::CODE_FULL;
      end
      return {1'b0, seen[3:0]};
   endfunction

   // apply one accepted beat to the grid copy and return the reply it causes
   function automatic tile_reply_type predict_reply(grid_beat_type beat);
      tile_reply_type reply;
      int c;
      int r;
      c = int'(beat.col);
      r = int'(beat.row);
      reply.visible = 1'b0;
      reply.code = '0;
      reply.in_grid = on_grid(c, r);
      if (beat.kind == tnc_pkg::KIND_WRITE) begin
         if (reply.in_grid) grid_bits[r][c] = beat.occupied;
      end else if (reply.in_grid && grid_bits[r][c]) begin
         reply.visible = 1'b1;
         reply.code = lookup_tile_code(c, r);
      end
      return reply;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic add_beat(logic kind, int c, int r, logic occ);
      grid_beat_type beat;
      beat.kind = kind;
      beat.col = tnc_pkg::POS_W'(c);
      beat.row = tnc_pkg::POS_W'(r);
      beat.occupied = occ;
      grid_beats_pending.push_back(beat);
   endtask

   task automatic add_write(int c, int r, logic occ);
      add_beat(tnc_pkg::KIND_WRITE, c, r, occ);
   endtask

   task automatic add_query(int c, int r);
      add_beat(tnc_pkg::KIND_QUERY, c, r, logic'($urandom_range(0, 1)));
   endtask

   function automatic int pick_pos();
      int edge_pos [4] = '{0, 1, tnc_pkg::POS_SPAN - 2, tnc_pkg::POS_SPAN - 1};
      if ($urandom_range(0, 3) == 0) begin
         return edge_pos[$urandom_range(0, 3)];
      end
      return $urandom_range(0, tnc_pkg::POS_SPAN - 1);
   endfunction

   // fill a stencil around one cell, punch a few holes, then look it up
   task automatic add_patch();
      int c;
      int r;
      int n;
      int holes;
      c = pick_pos();
      r = pick_pos();
      add_write(c, r, 1'b1);
      for (int k = 0; k < 12; k++) begin
         if (on_grid(c + step_dx[k], r + step_dy[k])) begin
            add_write(c + step_dx[k], r + step_dy[k], $urandom_range(0, 9) != 0);
         end
      end
      holes = $urandom_range(0, 2);
      for (int k = 0; k < holes; k++) begin
         n = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 11);
         if (on_grid(c + step_dx[n], r + step_dy[n])) begin
            add_write(c + step_dx[n], r + step_dy[n], 1'b0);
         end
      end
      add_query(c, r);
      for (int k = $urandom_range(0, 2); k > 0; k--) begin
         n = $urandom_range(0, 11);
         if (on_grid(c + step_dx[n], r + step_dy[n])) add_query(c + step_dx[n], r + step_dy[n]);
      end
      add_query($urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   task automatic add_noise();
      for (int k = 0; k < 8; k++) begin
         add_beat(logic'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 31),
                  logic'($urandom_range(0, 3) != 0));
      end
   endtask

   always @(posedge clock) begin : drive_beats
      grid_beat_type beat;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
         for (int r = 0; r < GRID_H; r++) begin
            for (int c = 0; c < GRID_W; c++) grid_bits[r][c] = 1'b0;
         end
      end else begin
         if (start && !busy) begin
            beat.kind = req_kind;
            beat.col = req_col;
            beat.row = req_row;
            beat.occupied = req_occupied;
            tile_replies_due.push_back(predict_reply(beat));
         end
         if (start && busy) begin
            // hold the current beat until the block takes it
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (grid_beats_pending.size() == 0) begin
            start <= 1'b0;
         end else if (grid_beats_pending.size() > QUIET_TAIL &&
                      $urandom_range(0, 15) < idle_odds) begin
            idle_left = $urandom_range(1, 14) - 1;
            start <= 1'b0;
         end else begin
            beat = grid_beats_pending.pop_front();
            req_kind <= beat.kind;
            req_col <= beat.col;
            req_row <= beat.row;
            req_occupied <= beat.occupied;
            start <= 1'b1;
            if ($urandom_range(0, 63) == 0) idle_odds = $urandom_range(0, 4);
         end
      end
   end

   always @(posedge clock) begin : check_replies
      tile_reply_type due;
      if (!reset && rsp_strobe) begin
         if (tile_replies_due.size() == 0) begin
            report_mismatch("result beat with no pending expectation");
         end else begin
            due = tile_replies_due.pop_front();
            if (rsp_cell_visible !== due.visible) begin
               report_mismatch($sformatf("cell_visible %b, want %b",
                                         rsp_cell_visible, due.visible));
            end
            if (rsp_tile_code !== due.code) begin
               report_mismatch($sformatf("tile_code %0d, want %0d", rsp_tile_code, due.code));
            end
            if (rsp_in_grid !== due.in_grid) begin
               report_mismatch($sformatf("in_grid %b, want %b", rsp_in_grid, due.in_grid));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      // empty grid, then full, inner corner and edge codes in the top-left corner
      add_query(5, 5);
      add_write(0, 0, 1'b1);
      add_write(1, 0, 1'b1);
      add_write(0, 1, 1'b1);
      add_write(1, 1, 1'b1);
      add_write(2, 0, 1'b1);
      add_write(0, 2, 1'b1);
      add_query(0, 0);
      add_write(1, 1, 1'b0);
      add_query(0, 0);
      add_write(1, 1, 1'b1);
      add_write(2, 0, 1'b0);
      add_query(0, 0);
      add_query(1, 0);
      // one inner corner per remaining grid corner
      add_write(31, 31, 1'b1);
      add_write(30, 31, 1'b1);
      add_write(31, 30, 1'b1);
      add_query(31, 31);
      add_write(31, 0, 1'b1);
      add_write(30, 0, 1'b1);
      add_write(31, 1, 1'b1);
      add_query(31, 0);
      add_write(0, 31, 1'b1);
      add_write(0, 30, 1'b1);
      add_write(1, 31, 1'b1);
      add_query(0, 31);
      while (grid_beats_pending.size() < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0) add_noise();
         else add_patch();
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (grid_beats_pending.size() != 0 || start || tile_replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tile_replies_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", tile_replies_due.size()));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
